// ----- design/lls_pkg.sv -----
package lls_pkg;

	localparam int SLOT_COUNT = 4096;
	localparam int SLOT_W     = 12;
	localparam int MAX_LEVELS = 8;
	localparam int LEVEL_W    = 3;
	localparam int COUNT_W    = 4;
	localparam int THR_W      = 20;
	localparam int RADIUS_W   = 24;
	localparam int DEPTH_W    = 32;
	localparam int CFG_W      = 24;
	localparam int FRAC_W     = 16;
	localparam int KEEP_W     = 17;
	localparam int BAND_CFG_W = 20;
	localparam int NUM_W      = 48;
	localparam int DEN_W      = 31;
	localparam int QUO_W      = 32;
	localparam int SCALED_W   = 40;
	localparam int BAND_W     = 24;
	localparam int COV_OUT_W  = 20;
	localparam int WEIGHT_W   = 17;
	localparam int MEM_W      = LEVEL_W + 1;

	localparam logic [KEEP_W-1:0] ONE_Q16 = KEEP_W'(65536);
	localparam logic [QUO_W-1:0] COV_ONE = QUO_W'(65536);
	localparam logic [COV_OUT_W-1:0] COV_OUT_MAX = '1;

	typedef enum logic [2:0] {
		CFG_COVERAGE_SCALE = 3'd0,
		CFG_HYSTERESIS     = 3'd1,
		CFG_FADE_BAND      = 3'd2,
		CFG_INV_TAN_FOV    = 3'd3,
		CFG_ORTHO_HEIGHT   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [SLOT_W-1:0]                    slot;
		logic [COUNT_W-1:0]                   count;
		logic [MAX_LEVELS-1:0][THR_W-1:0]     thr;
	} item_t;

	typedef struct packed {
		logic  special;
		item_t item;
	} d1_side_t;

	typedef struct packed {
		logic                  empty;
		logic                  fade;
		logic [LEVEL_W-1:0]    level;
		logic [COV_OUT_W-1:0]  cov_out;
	} res_t;

	typedef struct packed {
		logic raw;
		logic shr;
	} lls_hit_t;

	localparam int SIDE_W = $bits(d1_side_t);

endpackage

// ----- design/lls_ram.sv -----
module lls_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/lls_div.sv -----
module lls_div import lls_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [QUO_W-1:0]  quo,
	output logic [SIDE_W-1:0] side_out
);

	localparam int WIDE_W = NUM_W + QUO_W;

	logic              v_q    [QUO_W];
	logic [NUM_W-1:0]  rem_q  [QUO_W];
	logic [DEN_W-1:0]  den_q  [QUO_W];
	logic [QUO_W-1:0]  quo_q  [QUO_W];
	logic              sat_q  [QUO_W];
	logic [SIDE_W-1:0] side_q [QUO_W];

	logic [NUM_W-1:0]  rem_d  [QUO_W];
	logic              bit_d  [QUO_W];
	logic              sat_in;

	// quotient overflows 32 bits exactly when the top bits reach the divisor
	assign sat_in = {{(DEN_W-NUM_W+QUO_W){1'b0}}, num[NUM_W-1:QUO_W]} >= den;

	always_comb begin
		logic [NUM_W-1:0]  r_in;
		logic [DEN_W-1:0]  d_in;
		logic [WIDE_W-1:0] dsh;
		for (int k = 0; k < QUO_W; k++) begin
			r_in = (k == 0) ? num : rem_q[k-1];
			d_in = (k == 0) ? den : den_q[k-1];
			dsh  = {{(WIDE_W-DEN_W){1'b0}}, d_in} << (QUO_W - 1 - k);
			bit_d[k] = {{QUO_W{1'b0}}, r_in} >= dsh;
			rem_d[k] = bit_d[k] ? (r_in - dsh[NUM_W-1:0]) : r_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QUO_W; k++) v_q[k] <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < QUO_W; k++) v_q[k] <= (k == 0) ? in_valid : v_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QUO_W; k++) begin
				rem_q[k]  <= rem_d[k];
				den_q[k]  <= (k == 0) ? den : den_q[k-1];
				quo_q[k]  <= (k == 0) ? {{(QUO_W-1){1'b0}}, bit_d[k]}
				                      : {quo_q[k-1][QUO_W-2:0], bit_d[k]};
				sat_q[k]  <= (k == 0) ? sat_in : sat_q[k-1];
				side_q[k] <= (k == 0) ? side_in : side_q[k-1];
			end
		end
	end

	assign out_valid = v_q[QUO_W-1];
	assign quo       = sat_q[QUO_W-1] ? '1 : quo_q[QUO_W-1];
	assign side_out  = side_q[QUO_W-1];

endmodule

// ----- design/lls_lane.sv -----
module lls_lane import lls_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [SCALED_W-1:0] scaled,
	input  logic [THR_W-1:0]    thr,
	input  logic [KEEP_W-1:0]   keep,
	output lls_hit_t            hit
);

	logic [THR_W+KEEP_W-1:0]  prod;
	logic [THR_W+KEEP_W-17:0] shrunk;
	lls_hit_t                 hit_q;

	assign prod   = {{KEEP_W{1'b0}}, thr} * {{THR_W{1'b0}}, keep};
	assign shrunk = prod[THR_W+KEEP_W-1:16];

	// test plain and shrunk thresholds; the merge picks once the previous level is known
	always_ff @(posedge clk) begin
		if (en) begin
			hit_q.raw <= scaled >= SCALED_W'(thr);
			hit_q.shr <= scaled >= SCALED_W'(shrunk);
		end
	end

	assign hit = hit_q;

endmodule

// ----- design/lod_level_select_hysteresis.sv -----
// Level-of-detail selection with coverage hysteresis and cross-fade.
//
// Input channel (in_valid/in_ready): one beat per visible instance, carrying the
// slot, radius, view depth, level count and eight coverage thresholds.
// Output channel (out_valid/out_ready): one result beat per input beat, in order.
// Configuration: cfg_we/cfg_index/cfg_data write a register;
// write only while no beat is in flight.
//
// Throughput is one beat per cycle while the receiver takes its results and no
// sweep runs. From input acceptance to the result being shown, the beat passes
// stages s1 to s8, two 32-stage restoring dividers (coverage and fade weight,
// one quotient bit per stage) and the output register.
// Eight threshold lanes test the coverage side by side; a merge stage then
// picks the level against the slot's previous level read from the slot memory.
//
// After reset the slot memory is swept to "unknown", one slot a cycle: in_ready
// stays low until all 4096 slots are written. When the receiver stalls the whole
// pipeline holds; the output register keeps its beat until taken.
module lod_level_select_hysteresis import lls_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [SLOT_W-1:0]     slot,
	input  logic [RADIUS_W-1:0]   radius,
	input  logic signed [DEPTH_W-1:0] eye_depth,
	input  logic [COUNT_W-1:0]    level_count,
	input  logic [THR_W-1:0]      threshold_0,
	input  logic [THR_W-1:0]      threshold_1,
	input  logic [THR_W-1:0]      threshold_2,
	input  logic [THR_W-1:0]      threshold_3,
	input  logic [THR_W-1:0]      threshold_4,
	input  logic [THR_W-1:0]      threshold_5,
	input  logic [THR_W-1:0]      threshold_6,
	input  logic [THR_W-1:0]      threshold_7,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  draw_valid,
	output logic [LEVEL_W-1:0]    chosen_level,
	output logic                  fade_active,
	output logic [LEVEL_W-1:0]    fade_target,
	output logic [WEIGHT_W-1:0]   fade_weight,
	output logic [COV_OUT_W-1:0]  coverage_out
);

	// configuration registers
	logic [CFG_W-1:0]      scale_q;
	logic [FRAC_W-1:0]     hyst_q;
	logic [BAND_CFG_W-1:0] band_cfg_q;
	logic [CFG_W-1:0]      itan_q;
	logic [CFG_W-1:0]      ortho_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q    <= CFG_W'(65536);
			hyst_q     <= '0;
			band_cfg_q <= '0;
			itan_q     <= CFG_W'(65536);
			ortho_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COVERAGE_SCALE: scale_q    <= cfg_data;
				CFG_HYSTERESIS:     hyst_q     <= cfg_data[FRAC_W-1:0];
				CFG_FADE_BAND:      band_cfg_q <= cfg_data[BAND_CFG_W-1:0];
				CFG_INV_TAN_FOV:    itan_q     <= cfg_data;
				CFG_ORTHO_HEIGHT:   ortho_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: every stage moves when the output register is empty or being taken
	logic adv;
	logic clr_q;
	logic [SLOT_W-1:0] clr_idx_q;
	logic out_valid_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv && !clr_q;

	// sweep the slot memory to unknown after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == SLOT_W'(SLOT_COUNT - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// stage 1: capture the input beat
	logic                     v_s1;
	item_t                    it_s1;
	logic [RADIUS_W-1:0]      radius_s1;
	logic [DEPTH_W-1:0]       depth_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid && in_ready;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1.slot  <= slot;
			it_s1.count <= level_count;
			it_s1.thr   <= {threshold_7, threshold_6, threshold_5, threshold_4,
			                threshold_3, threshold_2, threshold_1, threshold_0};
			radius_s1   <= radius;
			depth_s1    <= eye_depth;
		end
	end

	// stage 2: form dividend and divisor
	logic [2*CFG_W-1:0] persp_prod;
	logic               v_s2;
	logic [NUM_W-1:0]   num_s2;
	logic [DEN_W-1:0]   den_s2;
	d1_side_t           side_s2;

	assign persp_prod = {{CFG_W{1'b0}}, radius_s1} * {{RADIUS_W{1'b0}}, itan_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ortho_q != '0) begin
				num_s2 <= NUM_W'({radius_s1, 17'b0});
				den_s2 <= DEN_W'(ortho_q);
			end else begin
				num_s2 <= NUM_W'(persp_prod);
				den_s2 <= depth_s1[DEN_W-1:0];
			end
			// perspective with depth not positive: coverage is 1.0
			side_s2.special <= (ortho_q == '0) && (depth_s1[DEPTH_W-1] || depth_s1 == '0);
			side_s2.item    <= it_s1;
		end
	end

	// coverage divider
	logic              d1_v;
	logic [QUO_W-1:0]  d1_q;
	logic [SIDE_W-1:0] d1_side_raw;
	d1_side_t          d1_side;

	lls_div u_cov_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s2),
		.num       (num_s2),
		.den       (den_s2),
		.side_in   (side_s2),
		.out_valid (d1_v),
		.quo       (d1_q),
		.side_out  (d1_side_raw)
	);

	assign d1_side = d1_side_t'(d1_side_raw);

	// stage 3: resolve coverage
	logic                 v_s3;
	logic [QUO_W-1:0]     cov_s3;
	logic [COV_OUT_W-1:0] cov_out_s3;
	item_t                it_s3;
	logic [QUO_W-1:0]     cov_d;

	assign cov_d = d1_side.special ? COV_ONE : d1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= d1_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cov_s3     <= cov_d;
			cov_out_s3 <= (cov_d[QUO_W-1:COV_OUT_W] != '0) ? COV_OUT_MAX : cov_d[COV_OUT_W-1:0];
			it_s3      <= d1_side.item;
		end
	end

	// stage 4: apply the bias scale
	logic [QUO_W+CFG_W-1:0] scale_prod;
	logic                   v_s4;
	logic [SCALED_W-1:0]    scaled_s4;
	logic [COV_OUT_W-1:0]   cov_out_s4;
	item_t                  it_s4;

	assign scale_prod = {{CFG_W{1'b0}}, cov_s3} * {{QUO_W{1'b0}}, scale_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			scaled_s4  <= scale_prod[QUO_W+CFG_W-1:16];
			cov_out_s4 <= cov_out_s3;
			it_s4      <= it_s3;
		end
	end

	// stage 5: threshold lanes, slot memory read
	logic [KEEP_W-1:0]    keep;
	lls_hit_t             hit_s5 [MAX_LEVELS];
	logic                 v_s5;
	logic [SCALED_W-1:0]  scaled_s5;
	logic [COV_OUT_W-1:0] cov_out_s5;
	item_t                it_s5;

	assign keep = ONE_Q16 - {1'b0, hyst_q};

	for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_lane
		lls_lane u_lane (
			.clk    (clk),
			.en     (adv),
			.scaled (scaled_s4),
			.thr    (it_s4.thr[g]),
			.keep   (keep),
			.hit    (hit_s5[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			scaled_s5  <= scaled_s4;
			cov_out_s5 <= cov_out_s4;
			it_s5      <= it_s4;
		end
	end

	logic [MEM_W-1:0]  mem_rdata;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	logic [MEM_W-1:0]  mem_wdata;
	logic              upd_we;
	logic [LEVEL_W-1:0] lvl_d;
	logic [COUNT_W-1:0] cnt_d;

	// last update, forwarded to the item right behind it
	logic               lw_v_q;
	logic [SLOT_W-1:0]  lw_slot_q;
	logic [LEVEL_W-1:0] lw_lvl_q;

	assign upd_we    = adv && v_s5 && (it_s5.count != '0);
	assign mem_we    = clr_q || upd_we;
	assign mem_waddr = clr_q ? clr_idx_q : it_s5.slot;
	assign mem_wdata = clr_q ? '0 : {1'b1, lvl_d};

	lls_ram #(.WIDTH(MEM_W), .DEPTH(SLOT_COUNT)) u_slot_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (adv),
		.raddr (it_s4.slot),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lw_v_q <= 1'b0;
		else if (adv) lw_v_q <= upd_we;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lw_slot_q <= it_s5.slot;
			lw_lvl_q  <= lvl_d;
		end
	end

	// merge: first lane that passes, shrinking thresholds past the previous level
	always_comb begin
		logic               known;
		logic [LEVEL_W-1:0] prev;
		logic               hit;
		if (lw_v_q && lw_slot_q == it_s5.slot) begin
			known = 1'b1;
			prev  = lw_lvl_q;
		end else begin
			known = mem_rdata[MEM_W-1];
			prev  = mem_rdata[LEVEL_W-1:0];
		end
		cnt_d = (it_s5.count > COUNT_W'(MAX_LEVELS)) ? COUNT_W'(MAX_LEVELS) : it_s5.count;
		lvl_d = LEVEL_W'(cnt_d - 1'b1);
		for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
			hit = (known && LEVEL_W'(i) > prev) ? hit_s5[i].shr : hit_s5[i].raw;
			if (COUNT_W'(i) < cnt_d && hit) begin
				lvl_d = LEVEL_W'(i);
			end
		end
	end

	// stage 6: chosen level
	logic                 v_s6;
	logic                 empty_s6;
	logic [LEVEL_W-1:0]   lvl_s6;
	logic [COUNT_W-1:0]   cnt_s6;
	logic [SCALED_W-1:0]  scaled_s6;
	logic [THR_W-1:0]     thr_s6;
	logic [COV_OUT_W-1:0] cov_out_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			empty_s6   <= it_s5.count == '0;
			lvl_s6     <= lvl_d;
			cnt_s6     <= cnt_d;
			scaled_s6  <= scaled_s5;
			thr_s6     <= it_s5.thr[lvl_d];
			cov_out_s6 <= cov_out_s5;
		end
	end

	// stage 7: fade band width
	logic [THR_W+BAND_CFG_W-1:0] band_prod;
	logic                 v_s7;
	logic                 empty_s7;
	logic [LEVEL_W-1:0]   lvl_s7;
	logic [COUNT_W-1:0]   cnt_s7;
	logic [SCALED_W-1:0]  scaled_s7;
	logic [THR_W-1:0]     thr_s7;
	logic [BAND_W-1:0]    band_s7;
	logic [COV_OUT_W-1:0] cov_out_s7;

	assign band_prod = {{BAND_CFG_W{1'b0}}, thr_s6} * {{THR_W{1'b0}}, band_cfg_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (adv) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			empty_s7   <= empty_s6;
			lvl_s7     <= lvl_s6;
			cnt_s7     <= cnt_s6;
			scaled_s7  <= scaled_s6;
			thr_s7     <= thr_s6;
			band_s7    <= band_prod[THR_W+BAND_CFG_W-1:16];
			cov_out_s7 <= cov_out_s6;
		end
	end

	// stage 8: band test and offset into the band
	logic              fade_d;
	logic [SCALED_W-1:0] diff_w;
	logic              v_s8;
	logic [BAND_W-1:0] diff_s8;
	logic [BAND_W-1:0] band_s8;
	res_t              res_s8;

	assign diff_w = scaled_s7 - SCALED_W'(thr_s7);
	assign fade_d = (band_cfg_q != '0)
	             && (({1'b0, lvl_s7} + 1'b1) < cnt_s7)
	             && (band_s7 != '0)
	             && (scaled_s7 >= SCALED_W'(thr_s7))
	             && (diff_w < SCALED_W'(band_s7));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (adv) v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s8        <= diff_w[BAND_W-1:0];
			band_s8        <= band_s7;
			res_s8.empty   <= empty_s7;
			res_s8.fade    <= fade_d && !empty_s7;
			res_s8.level   <= lvl_s7;
			res_s8.cov_out <= cov_out_s7;
		end
	end

	// fade weight divider
	logic              d2_v;
	logic [QUO_W-1:0]  d2_q;
	logic [SIDE_W-1:0] d2_side_raw;
	res_t              d2_res;

	lls_div u_fade_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s8),
		.num       (NUM_W'({diff_s8, 16'b0})),
		.den       (DEN_W'(band_s8)),
		.side_in   (SIDE_W'(res_s8)),
		.out_valid (d2_v),
		.quo       (d2_q),
		.side_out  (d2_side_raw)
	);

	assign d2_res = res_t'(d2_side_raw[$bits(res_t)-1:0]);

	// output register
	logic                 draw_q;
	logic [LEVEL_W-1:0]   level_q;
	logic                 fade_q;
	logic [LEVEL_W-1:0]   target_q;
	logic [WEIGHT_W-1:0]  weight_q;
	logic [COV_OUT_W-1:0] cov_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= d2_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			draw_q    <= !d2_res.empty;
			level_q   <= d2_res.empty ? '0 : d2_res.level;
			fade_q    <= d2_res.fade;
			target_q  <= d2_res.fade ? d2_res.level + 1'b1 : '0;
			weight_q  <= d2_res.fade ? ONE_Q16 - d2_q[WEIGHT_W-1:0] : '0;
			cov_out_q <= d2_res.empty ? '0 : d2_res.cov_out;
		end
	end

	assign out_valid    = out_valid_q;
	assign draw_valid   = draw_q;
	assign chosen_level = level_q;
	assign fade_active  = fade_q;
	assign fade_target  = target_q;
	assign fade_weight  = weight_q;
	assign coverage_out = cov_out_q;

	// hold off input beats for the whole sweep
	assert property (@(posedge clk) disable iff (!arst_n) clr_q |-> !in_ready)
		else $error("input accepted during slot memory sweep");

	// a sweep write and a level update never share the port
	assert property (@(posedge clk) disable iff (!arst_n) clr_q |-> !upd_we)
		else $error("level update during slot memory sweep");

	// a fade needs a drawn level with a finer one behind it
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fade_q |-> draw_q && level_q != '1 && target_q == level_q + 1'b1)
		else $error("fade on without a following level");

	// weight stays in (0, 1.0] while fading
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fade_q |-> weight_q != '0 && weight_q <= ONE_Q16)
		else $error("fade weight out of range");

endmodule
